>>> rtl/tafs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tafs_pkg: shared types and constants for the triangle angle unit
// Fixed-point constants of the law of cosines arccosine datapath.
// ----------------------------------------------------------------------------
package tafs_pkg;

    localparam int LEN_W   = 16;
    localparam int FRAC_W  = 7;
    localparam int ANG_W   = 8 + FRAC_W;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    localparam logic [ANG_W-1:0] FULL_ANGLE = ANG_W'(180 << FRAC_W);
    localparam logic [30:0]      Q_ONE      = 31'h4000_0000;
    localparam logic [31:0]      PI_Q30     = 32'd3373259427;
    localparam logic [29:0]      R2D_Q24    = 30'd961263669;

    // arccosine polynomial coefficients in q30, lowest order first
    localparam logic signed [32:0] COEF [8] = '{
        33'sd1686629690,
        -33'sd230423709,
        33'sd95540460,
        -33'sd53874249,
        33'sd33169905,
        -33'sd18348235,
        33'sd7161955,
        -33'sd1355589
    };

    // classified request handed from the front part to the back part
    typedef struct packed {
        logic [32:0]      m;      // |b*b + c*c - a*a|
        logic [32:0]      d;      // 2*b*c
        logic             neg;    // ratio below zero
        logic             qone;   // ratio magnitude is at least one
        logic             pinned; // result fixed by the front part
        logic             inv;
        logic [ANG_W-1:0] fangle;
    } tafs_ent_t;

    typedef struct packed {
        logic [33:0]        m;
        logic [32:0]        d;
        logic [30:0]        q;
        logic signed [32:0] p;
        logic [62:0]        prod;
        logic               psn;
        logic [62:0]        rem;
        logic [30:0]        root;
        logic [31:0]        r;
        logic               neg;
        logic               qone;
        logic               pinned;
        logic               inv;
        logic [ANG_W-1:0]   fangle;
    } tafs_bk_t;

endpackage

>>> rtl/tafs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tafs_front: squares the sides and classifies each request
// Two register stages: products, then ratio terms and special cases.
// ----------------------------------------------------------------------------
module tafs_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tafs_pkg::LEN_W-1:0]   side_a,
    input  logic [tafs_pkg::LEN_W-1:0]   side_b,
    input  logic [tafs_pkg::LEN_W-1:0]   side_c,
    output logic                         ent_valid,
    input  logic                         ent_full,
    output tafs_pkg::tafs_ent_t          ent
);
    import tafs_pkg::*;

    logic        s1_vld_reg, s2_vld_reg;
    logic        adv;
    logic [31:0] a2_reg, b2_reg, c2_reg, bc_reg;
    logic        zero_reg;
    logic [32:0] sum;
    logic        neg;
    logic [32:0] mag;
    logic [32:0] dd;
    logic        oor;
    tafs_ent_t   ent_reg, ent_next;

    assign adv      = !s2_vld_reg || !ent_full;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_reg   <= 32'(side_a) * 32'(side_a);
            b2_reg   <= 32'(side_b) * 32'(side_b);
            c2_reg   <= 32'(side_c) * 32'(side_c);
            bc_reg   <= 32'(side_b) * 32'(side_c);
            zero_reg <= (side_b == '0) || (side_c == '0);
            ent_reg  <= ent_next;
        end
    end

    assign sum = {1'b0, b2_reg} + {1'b0, c2_reg};
    assign neg = {1'b0, a2_reg} > sum;
    assign mag = neg ? ({1'b0, a2_reg} - sum) : (sum - {1'b0, a2_reg});
    assign dd  = {bc_reg, 1'b0};
    assign oor = dd < mag;

    always_comb
    begin
        ent_next.m      = mag;
        ent_next.d      = dd;
        ent_next.neg    = neg;
        ent_next.qone   = mag >= dd;
        ent_next.pinned = zero_reg || oor;
        ent_next.inv    = zero_reg || oor;
        ent_next.fangle = (!zero_reg && oor && neg) ? FULL_ANGLE : '0;
    end

    assign ent_valid = s2_vld_reg;
    assign ent       = ent_reg;

endmodule

>>> rtl/tafs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tafs_queue: short request queue between front and back parts
// Four entries with a fill count.
// ----------------------------------------------------------------------------
module tafs_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 full,
    input  tafs_pkg::tafs_ent_t  push_ent,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output tafs_pkg::tafs_ent_t  pop_ent
);
    import tafs_pkg::*;

    tafs_ent_t          mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    cnt_reg;
    logic               push, pop;

    assign full      = cnt_reg == (QPTR_W+1)'(QDEPTH);
    assign pop_valid = cnt_reg != '0;
    assign push      = push_valid && !full;
    assign pop       = pop_valid && pop_ready;
    assign pop_ent   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_ent;
    end

endmodule

>>> rtl/tafs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tafs_back: pipelined ratio divider, arccosine and degree scaling
// One stage per quotient bit, two per horner step, one per root bit.
// ----------------------------------------------------------------------------
module tafs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tafs_pkg::tafs_ent_t           ent,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tafs_pkg::ANG_W-1:0]    angle,
    output logic                          inv
);
    import tafs_pkg::*;

    localparam int DIV_N = 30;
    localparam int RND_S = DIV_N;
    localparam int HOR_S = RND_S + 1;
    localparam int SQ_S  = HOR_S + 14;
    localparam int PS_S  = SQ_S + 31;
    localparam int NST   = PS_S + 4;

    tafs_bk_t       pipe_reg [1:NST];
    logic [NST:1]   vld_reg;
    tafs_bk_t       stg_in   [NST];
    tafs_bk_t       stg_out  [NST];
    logic           en;

    assign en        = !vld_reg[NST] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NST];
    assign angle     = pipe_reg[NST].fangle;
    assign inv       = pipe_reg[NST].inv;

    always_comb
    begin
        stg_in[0]        = '0;
        stg_in[0].m      = {1'b0, ent.m};
        stg_in[0].d      = ent.d;
        stg_in[0].neg    = ent.neg;
        stg_in[0].qone   = ent.qone;
        stg_in[0].pinned = ent.pinned;
        stg_in[0].inv    = ent.inv;
        stg_in[0].fangle = ent.fangle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-1:1], in_valid};
    end

    genvar g;
    generate
        for (g = 0; g < NST; g++)
        begin : g_stage
            if (g > 0)
            begin : g_link
                assign stg_in[g] = pipe_reg[g];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    pipe_reg[g+1] <= stg_out[g];
            end

            if (g < RND_S)
            begin : g_div
                logic [33:0] sh;
                assign sh = {stg_in[g].m[32:0], 1'b0};
                always_comb
                begin
                    stg_out[g] = stg_in[g];
                    if (sh >= {1'b0, stg_in[g].d})
                    begin
                        stg_out[g].m = sh - {1'b0, stg_in[g].d};
                        stg_out[g].q = {stg_in[g].q[29:0], 1'b1};
                    end
                    else
                    begin
                        stg_out[g].m = sh;
                        stg_out[g].q = {stg_in[g].q[29:0], 1'b0};
                    end
                end
            end
            else if (g == RND_S)
            begin : g_rnd
                logic        rb;
                logic [30:0] qr, qf, qc;
                assign rb = {stg_in[g].m[32:0], 1'b0} >= {1'b0, stg_in[g].d};
                assign qr = stg_in[g].q + {30'b0, rb};
                assign qf = (stg_in[g].qone || qr > Q_ONE) ? Q_ONE : qr;
                assign qc = Q_ONE - qf;
                always_comb
                begin
                    stg_out[g]      = stg_in[g];
                    stg_out[g].q    = qf;
                    stg_out[g].p    = COEF[7];
                    stg_out[g].rem  = {2'b0, qc, 30'b0};
                    stg_out[g].root = '0;
                end
            end
            else if (g < SQ_S && ((g - HOR_S) % 2) == 0)
            begin : g_hmul
                logic [31:0] mag;
                logic [62:0] pr;
                assign mag = stg_in[g].p[32] ? 32'(-stg_in[g].p) : 32'(stg_in[g].p);
                assign pr  = mag * stg_in[g].q;
                always_comb
                begin
                    stg_out[g]      = stg_in[g];
                    stg_out[g].psn  = stg_in[g].p[32];
                    stg_out[g].prod = pr;
                end
            end
            else if (g < SQ_S)
            begin : g_hadd
                localparam int J = (g - HOR_S) / 2;
                logic [62:0] rs;
                logic [32:0] t;
                assign rs = (stg_in[g].prod + 63'd536870912) >> 30;
                assign t  = rs[32:0];
                always_comb
                begin
                    stg_out[g]   = stg_in[g];
                    stg_out[g].p = $signed(stg_in[g].psn ? (~t + 33'd1) : t) + COEF[6-J];
                end
            end
            else if (g < PS_S)
            begin : g_sqrt
                localparam int K = PS_S - 1 - g;
                logic [62:0] tr;
                assign tr = ({32'b0, stg_in[g].root} << (K + 1)) + (63'd1 << (2 * K));
                always_comb
                begin
                    stg_out[g] = stg_in[g];
                    if (stg_in[g].rem >= tr)
                    begin
                        stg_out[g].rem  = stg_in[g].rem - tr;
                        stg_out[g].root = stg_in[g].root | (31'd1 << K);
                    end
                end
            end
            else if (g == PS_S)
            begin : g_pmul
                logic [31:0] pc;
                logic [62:0] pr;
                assign pc = stg_in[g].p[32] ? 32'd0 : stg_in[g].p[31:0];
                assign pr = pc * stg_in[g].root;
                always_comb
                begin
                    stg_out[g]      = stg_in[g];
                    stg_out[g].prod = pr;
                end
            end
            else if (g == PS_S + 1)
            begin : g_rad
                logic [62:0] rs;
                logic [31:0] rc;
                assign rs = (stg_in[g].prod + 63'd536870912) >> 30;
                assign rc = (rs > {31'b0, PI_Q30}) ? PI_Q30 : rs[31:0];
                always_comb
                begin
                    stg_out[g]   = stg_in[g];
                    stg_out[g].r = stg_in[g].neg ? (PI_Q30 - rc) : rc;
                end
            end
            else if (g == PS_S + 2)
            begin : g_dmul
                logic [62:0] pr;
                assign pr = stg_in[g].r * R2D_Q24;
                always_comb
                begin
                    stg_out[g]      = stg_in[g];
                    stg_out[g].prod = pr;
                end
            end
            else
            begin : g_deg
                logic [62:0] deg;
                assign deg = (stg_in[g].prod + (63'd1 << (53 - FRAC_W))) >> (54 - FRAC_W);
                always_comb
                begin
                    stg_out[g] = stg_in[g];
                    if (!stg_in[g].pinned)
                        stg_out[g].fangle = (deg > {48'b0, FULL_ANGLE}) ? FULL_ANGLE
                                                                       : deg[ANG_W-1:0];
                end
            end
        end
    endgenerate

endmodule

>>> rtl/triangle_angle_from_sides_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_angle_from_sides_unit: law of cosines angle
// Angle opposite side a from sides a, b, c, in 1/128 degree.
// ----------------------------------------------------------------------------
// s_tdata carries a request of three unsigned 16-bit sides; m_tdata returns
// the angle (0 to 180 degrees, 1/128 degree steps) and m_tuser the invalid
// flag, set when b or c is zero or the sides form no triangle.
// One request is taken every cycle while s_tready is high. A result passes
// through two front stages, the queue, then 80 back stages set by the 30
// quotient bits, one rounding stage, seven horner steps of two stages each,
// the 31 root bits and four scaling stages.
// The front part keeps taking requests while the queue has room,
// so a stalled receiver holds the back pipeline and the four-entry queue
// fills before s_tready drops. Results come out in request order.
// Reset empties the pipeline and the queue; no other state is kept.
// ----------------------------------------------------------------------------
module triangle_angle_from_sides_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // side_opposite, side_adjacent_one, side_adjacent_two
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // angle_deg, zero pad
    output logic        m_tuser    // invalid
);
    import tafs_pkg::*;

    tafs_ent_t          f_ent, q_ent;
    logic               f_valid, q_full, q_valid, b_ready;
    logic [ANG_W-1:0]   angle;

    tafs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .side_a    (s_tdata[15:0]),
        .side_b    (s_tdata[31:16]),
        .side_c    (s_tdata[47:32]),
        .ent_valid (f_valid),
        .ent_full  (q_full),
        .ent       (f_ent)
    );

    tafs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .full       (q_full),
        .push_ent   (f_ent),
        .pop_valid  (q_valid),
        .pop_ready  (b_ready),
        .pop_ent    (q_ent)
    );

    tafs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (b_ready),
        .ent       (q_ent),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .angle     (angle),
        .inv       (m_tuser)
    );

    assign m_tdata = {1'b0, angle};

endmodule

>>> tb/sv/triangle_angle_from_sides_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_angle_from_sides_unit_tb: law of cosines angle unit testbench
// Sends directed and random side triples through the stream input, predicts
// each angle and invalid flag in exact integer arithmetic, and checks every
// result in order under random idling, a long receiver stall and two drains.
// ----------------------------------------------------------------------------
module triangle_angle_from_sides_unit_tb;
    import tafs_pkg::*;

    typedef struct {
        logic [LEN_W-1:0] side_a;
        logic [LEN_W-1:0] side_b;
        logic [LEN_W-1:0] side_c;
        bit               drain;   // marker: wait until all results are back
    } tri_req_t;

    typedef struct {
        logic [ANG_W-1:0] angle;
        logic             inv;
    } angle_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // side_opposite, side_adjacent_one, side_adjacent_two
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // angle_deg, zero pad
    logic        m_tuser;   // invalid

    tri_req_t    pending_reqs[$];
    angle_res_t  expected_angles[$];
    tri_req_t    cur_req;
    int          mismatches;
    int          results_seen;
    int          invalid_seen;
    int          cycle_cnt;
    int          hold_cnt;
    bit          req_taken;
    bit          draining;
    bit          stim_done;

    longint          poly_q30[8];
    longint unsigned pi_q30;
    longint unsigned r2d_q24;

    triangle_angle_from_sides_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic angle_res_t calc_angle(input logic [LEN_W-1:0] a,
                                              input logic [LEN_W-1:0] b,
                                              input logic [LEN_W-1:0] c);
        angle_res_t      res;
        logic [127:0]    sum;
        logic [127:0]    sq;
        logic [127:0]    m;
        logic [127:0]    d;
        longint unsigned q;
        longint unsigned v;
        longint unsigned root;
        longint unsigned rbit;
        longint unsigned s;
        longint unsigned r;
        longint unsigned deg;
        longint unsigned mag;
        longint unsigned prod;
        longint          p;
        bit              neg;
        int              i;
        res.angle = '0;
        res.inv   = 1'b0;
        if (b == 0 || c == 0) begin
            res.inv = 1'b1;
            return res;
        end
        sum = 128'(b) * b + 128'(c) * c;
        sq  = 128'(a) * a;
        neg = sum < sq;
        m   = neg ? sq - sum : sum - sq;
        d   = 128'(b) * c * 2;
        if (d < m) begin
            res.inv   = 1'b1;
            res.angle = neg ? FULL_ANGLE : '0;
            return res;
        end
        q = 0;
        if (m >= d) begin
            q = 64'd1 << 30;
        end
        else begin
            // 30-bit restoring division, then round half up
            for (i = 0; i < 30; i++) begin
                m = m << 1;
                q = q << 1;
                if (m >= d) begin
                    m = m - d;
                    q = q | 1;
                end
            end
            if ((m << 1) >= d)
                q++;
        end
        if (q > (64'd1 << 30))
            q = 64'd1 << 30;
        p = poly_q30[7];
        for (i = 6; i >= 0; i--) begin
            mag  = p < 0 ? longint'(-p) : longint'(p);
            prod = (mag * q + (64'd1 << 29)) >> 30;
            p    = (p < 0 ? -longint'(prod) : longint'(prod)) + poly_q30[i];
        end
        if (p < 0)
            p = 0;
        v    = ((64'd1 << 30) - q) << 30;
        root = 0;
        rbit = 64'd1 << 62;
        while (rbit > v)
            rbit = rbit >> 2;
        while (rbit != 0) begin
            if (v >= root + rbit) begin
                v    = v - (root + rbit);
                root = (root >> 1) + rbit;
            end
            else begin
                root = root >> 1;
            end
            rbit = rbit >> 2;
        end
        s = root;
        r = (longint'(p) * s + (64'd1 << 29)) >> 30;
        if (r > pi_q30)
            r = pi_q30;
        if (neg)
            r = pi_q30 - r;
        deg = (r * r2d_q24 + (64'd1 << (53 - FRAC_W))) >> (54 - FRAC_W);
        res.angle = deg > FULL_ANGLE ? FULL_ANGLE : ANG_W'(deg);
        return res;
    endfunction

    task automatic add_req(input int a, input int b, input int c);
        tri_req_t t;
        t.side_a = LEN_W'(a);
        t.side_b = LEN_W'(b);
        t.side_c = LEN_W'(c);
        t.drain  = 1'b0;
        pending_reqs.push_back(t);
    endtask

    task automatic add_drain();
        tri_req_t t;
        t = '{default: '0};
        t.drain = 1'b1;
        pending_reqs.push_back(t);
    endtask

    function automatic bit idle_now();
        // quiet window with no idling at all
        if (cycle_cnt > 300 && cycle_cnt < 700)
            return 1'b0;
        return $urandom_range(99) < 29;
    endfunction

    // sender
    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_tvalid || req_taken) begin
                if (draining && expected_angles.size() == 0)
                    draining = 1'b0;
                if (!draining && pending_reqs.size() > 0 && pending_reqs[0].drain) begin
                    void'(pending_reqs.pop_front());
                    draining = 1'b1;
                end
                if (draining || pending_reqs.size() == 0 || idle_now()) begin
                    s_tvalid <= 1'b0;
                end
                else begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata  <= {cur_req.side_c, cur_req.side_b, cur_req.side_a};
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // receiver, with one long hold-off
    always @(negedge clk) begin
        cycle_cnt++;
        if (cycle_cnt == 750)
            hold_cnt = 400;
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= !idle_now();
        end
    end

    // request and result monitor
    always @(posedge clk) begin
        angle_res_t got;
        angle_res_t want;
        req_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            expected_angles.push_back(calc_angle(s_tdata[15:0], s_tdata[31:16],
                                                 s_tdata[47:32]));
        if (rst_n && m_tvalid && m_tready) begin
            got.angle = m_tdata[ANG_W-1:0];
            got.inv   = m_tuser;
            results_seen++;
            if (got.inv)
                invalid_seen++;
            if (expected_angles.size() == 0) begin
                report_mismatch($sformatf("unexpected result angle=%0d inv=%0b",
                                          got.angle, got.inv));
            end
            else begin
                want = expected_angles.pop_front();
                if (got.angle !== want.angle)
                    report_mismatch($sformatf("angle got %0d want %0d",
                                              got.angle, want.angle));
                if (got.inv !== want.inv)
                    report_mismatch($sformatf("invalid got %0b want %0b",
                                              got.inv, want.inv));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int     i;
        int     b;
        int     c;
        int     lo;
        int     hi;
        int     wbits;
        longint unsigned coef_n[8];
        logic [127:0] tmp;
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        req_taken = 1'b0;
        draining  = 1'b0;
        stim_done = 1'b0;
        cycle_cnt = 0;
        hold_cnt  = 0;
        mismatches   = 0;
        results_seen = 0;
        invalid_seen = 0;

        coef_n = '{64'd15707963050, 64'd2145988016, 64'd889789874, 64'd501743046,
                   64'd308918810, 64'd170881256, 64'd66700901, 64'd12624911};
        for (i = 0; i < 8; i++) begin
            tmp = (128'(coef_n[i]) * (128'd1 << 30) + 128'd5000000000) / 128'd10000000000;
            poly_q30[i] = (i % 2 == 1) ? -longint'(tmp) : longint'(tmp);
        end
        tmp     = (128'd3141592654 * (128'd1 << 30) + 128'd500000000) / 128'd1000000000;
        pi_q30  = 64'(tmp);
        tmp     = (128'd5729577951 * (128'd1 << 24) + 128'd50000000) / 128'd100000000;
        r2d_q24 = 64'(tmp);

        // directed corners
        add_req(0, 0, 0);
        add_req(5, 0, 7);
        add_req(5, 7, 0);
        add_req(65535, 65535, 65535);
        add_req(0, 65535, 65535);
        add_req(1, 1, 1);
        add_req(5, 3, 4);
        add_req(3, 4, 5);
        add_req(10, 4, 6);         // degenerate, ratio minus one
        add_req(2, 4, 6);          // degenerate, ratio plus one
        add_req(11, 4, 6);         // no triangle, too long
        add_req(1, 4, 6);          // no triangle, too short
        add_req(65535, 1, 1);
        add_req(0, 1, 65535);
        add_req(65535, 32768, 32767);
        add_req(65535, 65534, 1);
        add_req(1, 65535, 65535);
        add_req(0, 7, 7);
        add_req(65535, 1, 65535);
        add_req(46341, 32768, 32768);
        add_drain();

        for (i = 0; i < 1350; i++) begin
            if (i == 700)
                add_drain();
            if ($urandom_range(99) < 75) begin
                // well-formed triangle at a random scale
                wbits = $urandom_range(16, 1);
                b  = $urandom_range((1 << wbits) - 1, 1);
                c  = $urandom_range((1 << wbits) - 1, 1);
                lo = b > c ? b - c : c - b;
                hi = b + c > 65535 ? 65535 : b + c;
                add_req($urandom_range(hi, lo), b, c);
            end
            else begin
                add_req($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_reqs.size() == 0 && !draining);
        @(negedge clk);
        wait (!s_tvalid && expected_angles.size() == 0);
        repeat (200) @(posedge clk);
        if (expected_angles.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_angles.size()));

        $display("run covered %0d triangles, %0d flagged invalid, with a long output stall",
                 results_seen, invalid_seen);
        $display("and two full drains; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
rtl/tafs_pkg.sv
rtl/tafs_front.sv
rtl/tafs_queue.sv
rtl/tafs_back.sv
rtl/triangle_angle_from_sides_unit.sv
tb/sv/triangle_angle_from_sides_unit_tb.sv
